@@ hdl/qau_pkg.sv @@
// qau_pkg: shared types, opcodes and constant tables of the quaternion unit
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package qau_pkg;

    // word width of every quaternion component field
    localparam int WORD_BITS = 32;

    // opcodes
    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_MUL   = 4'd1;
    localparam logic [3:0] OP_CONJ  = 4'd2;
    localparam logic [3:0] OP_INV   = 4'd3;
    localparam logic [3:0] OP_MAG   = 4'd4;
    localparam logic [3:0] OP_NORM  = 4'd5;
    localparam logic [3:0] OP_ROTQ  = 4'd6;
    localparam logic [3:0] OP_ROTV  = 4'd7;
    localparam logic [3:0] OP_IROTV = 4'd8;

    // request and result payloads
    typedef struct packed {
        logic        [3:0]           opcode;
        logic signed [WORD_BITS-1:0] a_x;
        logic signed [WORD_BITS-1:0] a_y;
        logic signed [WORD_BITS-1:0] a_z;
        logic signed [WORD_BITS-1:0] a_w;
        logic signed [WORD_BITS-1:0] b_x;
        logic signed [WORD_BITS-1:0] b_y;
        logic signed [WORD_BITS-1:0] b_z;
        logic signed [WORD_BITS-1:0] b_w;
    } t_req;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] r_x;
        logic signed [WORD_BITS-1:0] r_y;
        logic signed [WORD_BITS-1:0] r_z;
        logic signed [WORD_BITS-1:0] r_w;
        logic                        saturated;
        logic                        norm_skipped;
    } t_rsp;

    // operation class decided by the front end
    typedef enum logic [3:0] {
        CL_NONE, CL_ADD, CL_MUL, CL_CONJ, CL_INV,
        CL_MAG, CL_NORM, CL_ROTQ, CL_ROTV, CL_IROTV
    } t_cls;

    // queue entry
    typedef struct packed {
        t_cls cls;
        t_req req;
    } t_qitem;

    // back end sequencer
    typedef enum logic [3:0] {
        ST_IDLE, ST_MAC, ST_DRAIN, ST_FIN, ST_SQRT, ST_SQFIN,
        ST_DSET, ST_DIV, ST_DIVFIN, ST_DONE
    } t_state;

    // which product or sum the multiply-accumulate pass builds
    typedef enum logic [2:0] {
        PH_HAB, PH_HBA, PH_HPQ, PH_SSA, PH_SSB, PH_ROT1, PH_ROT2
    } t_phase;

    // hamilton product terms, indexed {component, term}: left, right, negate
    localparam logic [1:0] HAM_L [16] = '{
        2'd3, 2'd2, 2'd0, 2'd1,
        2'd3, 2'd0, 2'd1, 2'd2,
        2'd3, 2'd0, 2'd1, 2'd2,
        2'd3, 2'd0, 2'd1, 2'd2
    };
    localparam logic [1:0] HAM_R [16] = '{
        2'd0, 2'd1, 2'd3, 2'd2,
        2'd1, 2'd2, 2'd3, 2'd0,
        2'd2, 2'd1, 2'd0, 2'd3,
        2'd3, 2'd0, 2'd1, 2'd2
    };
    localparam logic HAM_N [16] = '{
        1'b0, 1'b1, 1'b0, 1'b0,
        1'b0, 1'b1, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b1, 1'b0,
        1'b0, 1'b1, 1'b1, 1'b1
    };

    // next and second-next vector axis, cyclic over x y z
    function automatic logic [1:0] axis_nxt1(input logic [1:0] i);
        logic [1:0] r;
        case (i)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] axis_nxt2(input logic [1:0] i);
        logic [1:0] r;
        case (i)
            2'd0:    r = 2'd2;
            2'd1:    r = 2'd0;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/quaternion_arithmetic_unit_core.sv @@
// quaternion_arithmetic_unit_core: top level, front end, queue and back end
// depends on qau_pkg, qau_front, qau_queue, qau_back
//
//   channel   | signals                | handshake
//   ----------+------------------------+----------------------------------
//   request   | i_req (t_req)          | taken when start high and busy low
//   result    | o_rsp (t_rsp)          | o_done high for one cycle
//
// front end takes a request every cycle until the queue fills; back end runs one at a time
// back end: add, conjugate and unused codes skip the multiply-accumulate; inverse and
// quaternion rotation divide only when scaling is needed, normalize only when not skipped
// each division: setup, one step per quotient bit (max(W+2F+2, 2W+2) bits), finish
// reset is synchronous and clears queue and sequencer; the receiver cannot stall
`timescale 1ns / 1ps
`default_nettype none

module quaternion_arithmetic_unit_core #(
    parameter int FRAC_BITS   = 28,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    input  qau_pkg::t_req   i_req,
    output logic            busy,
    output logic            o_done,
    output qau_pkg::t_rsp   o_rsp
);
    import qau_pkg::*;

    t_qitem w_fitem, w_qitem;
    logic   w_push, w_full, w_qvld, w_pop;

    // request capture and classification
    qau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_push  (w_push),
        .o_item  (w_fitem),
        .i_full  (w_full)
    );

    // decoupling queue
    qau_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_fitem),
        .o_full  (w_full),
        .o_vld   (w_qvld),
        .o_item  (w_qitem),
        .i_pop   (w_pop)
    );

    // arithmetic sequencer
    qau_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_qvld),
        .i_item  (w_qitem),
        .o_pop   (w_pop),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire

@@ hdl/qau_front.sv @@
// qau_front: request capture and opcode classification
// depends on qau_pkg; feeds qau_queue
`timescale 1ns / 1ps
`default_nettype none

module qau_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  qau_pkg::t_req      i_req,
    output logic               busy,
    output logic               o_push,
    output qau_pkg::t_qitem    o_item,
    input  wire logic          i_full
);
    import qau_pkg::*;

    logic   r_vld, n_vld;
    t_qitem r_item;
    t_cls   w_cls;
    logic   w_acc;

    // opcode decode
    always_comb begin
        unique case (i_req.opcode)
            OP_ADD:   w_cls = CL_ADD;
            OP_MUL:   w_cls = CL_MUL;
            OP_CONJ:  w_cls = CL_CONJ;
            OP_INV:   w_cls = CL_INV;
            OP_MAG:   w_cls = CL_MAG;
            OP_NORM:  w_cls = CL_NORM;
            OP_ROTQ:  w_cls = CL_ROTQ;
            OP_ROTV:  w_cls = CL_ROTV;
            OP_IROTV: w_cls = CL_IROTV;
            default:  w_cls = CL_NONE;
        endcase
    end

    // hold stage: stalls only when the queue is full
    assign busy   = r_vld & i_full;
    assign o_push = r_vld & ~i_full;
    assign o_item = r_item;
    assign w_acc  = start & ~busy;
    assign n_vld  = w_acc | (r_vld & i_full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        if (w_acc) begin
            r_item <= '{cls: w_cls, req: i_req};
        end
    end

endmodule

`default_nettype wire

@@ hdl/qau_queue.sv @@
// qau_queue: small request queue between front end and back end
// depends on qau_pkg
`timescale 1ns / 1ps
`default_nettype none

module qau_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  qau_pkg::t_qitem    i_item,
    output logic               o_full,
    output logic               o_vld,
    output qau_pkg::t_qitem    o_item,
    input  wire logic          i_pop
);
    import qau_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_qitem          r_mem [DEPTH];
    logic [AW-1:0]   r_wp, r_rp, n_wp, n_rp;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            w_wr, w_rd;

    assign o_full = (r_cnt == CW'(DEPTH));
    assign o_vld  = (r_cnt != '0);
    assign o_item = r_mem[r_rp];
    assign w_wr   = i_push & ~o_full;
    assign w_rd   = i_pop & o_vld;

    // pointer wrap and fill count
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_wr) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (w_rd) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (w_wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

`default_nettype wire

@@ hdl/qau_back.sv @@
// qau_back: sequenced datapath with one shared multiplier, a bit-serial
// square root and a bit-serial divider; depends on qau_pkg
`timescale 1ns / 1ps
`default_nettype none

module qau_back #(
    parameter int FRAC_BITS = 28
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_vld,
    input  qau_pkg::t_qitem    i_item,
    output logic               o_pop,
    output logic               o_done,
    output qau_pkg::t_rsp      o_rsp
);
    import qau_pkg::*;

    localparam int W    = WORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int PW   = 2 * W + 1;
    localparam int ACCW = 2 * W + 3;
    localparam int NW   = (W + 2 * F + 2 > 2 * W + 2) ? W + 2 * F + 2 : 2 * W + 2;
    localparam int SW   = NW + 3;
    localparam int SQ   = W + 1;
    localparam int RMW  = SQ + 4;
    localparam int CW   = $clog2(NW + 1);
    localparam longint THRESH = ((longint'(1) << F) + 10) / 20;

    typedef logic signed [W-1:0] t_word;

    localparam logic signed [SW-1:0] S_MAX = {{(SW - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {{(SW - W + 1){1'b1}}, {(W - 1){1'b0}}};
    localparam t_word W_MAX = {1'b0, {(W - 1){1'b1}}};
    localparam t_word W_MIN = {1'b1, {(W - 1){1'b0}}};
    localparam logic signed [ACCW-1:0] RND_F  = {{(ACCW - 1){1'b0}}, 1'b1} << (F - 1);
    localparam logic signed [ACCW-1:0] RND_F2 = {{(ACCW - 1){1'b0}}, 1'b1} << (F - 2);
    localparam logic [ACCW-1:0] ONE2 = {{(ACCW - 1){1'b0}}, 1'b1} << (2 * F);
    localparam logic [SQ:0] TH_M = (SQ + 1)'(THRESH);

    function automatic t_word sat_w(input logic signed [SW-1:0] v);
        t_word r;
        if (v > S_MAX) begin
            r = W_MAX;
        end else if (v < S_MIN) begin
            r = W_MIN;
        end else begin
            r = v[W-1:0];
        end
        return r;
    endfunction

    function automatic logic sat_ov(input logic signed [SW-1:0] v);
        return (v > S_MAX) || (v < S_MIN);
    endfunction

    // conjugate component: vector part negated
    function automatic logic signed [SW-1:0] conj_c(input t_word x, input logic [1:0] idx);
        logic signed [SW-1:0] e;
        e = SW'(x);
        return (idx == 2'd3) ? e : -e;
    endfunction

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    t_cls   r_cls, n_cls;
    logic [1:0] r_comp, n_comp, r_k, n_k;
    t_word r_a [4], n_a [4];
    t_word r_b [4], n_b [4];
    t_word r_p [4], n_p [4];
    t_word r_q [4], n_q [4];
    t_word r_o [4], n_o [4];
    t_word ld_a [4], ld_b [4];
    logic r_fl, n_fl, r_skip, n_skip, r_dinv, n_dinv;
    logic signed [PW-1:0]   r_prod, n_prod;
    logic signed [ACCW-1:0] r_acc, n_acc;
    logic [ACCW-1:0]  r_ss, n_ss;
    logic [SQ:0]      r_mag, n_mag, r_root, n_root, mag_rnd;
    logic [2*SQ-1:0]  r_sqs, n_sqs;
    logic [RMW-1:0]   r_sqr, n_sqr, s_sh, s_tr;
    logic [NW-1:0]    r_num, n_num, r_den, n_den, d_den, d_num;
    logic [NW:0]      r_rem, n_rem, v_sh;
    logic             r_dneg, n_dneg, v_ge, s_ge;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_done, n_done;
    t_rsp             r_rsp, n_rsp;

    t_word mul_x, mul_y;
    logic  mul_neg;
    logic signed [2*W-1:0] mul_raw;
    logic signed [PW-1:0]  mul_p;
    logic [1:0] rj, rk;
    logic [3:0] hi;
    logic       inv_rot, ss_big, mag_small;
    logic signed [ACCW-1:0] acc_rf, acc_r2;
    logic signed [SW-1:0]   fin_rf, fin_r2, q_s, dval;
    t_word       d_src;
    logic signed [W:0] d_sv;
    logic [W:0]  d_abs;

    // request operands
    assign ld_a[0] = i_item.req.a_x;
    assign ld_a[1] = i_item.req.a_y;
    assign ld_a[2] = i_item.req.a_z;
    assign ld_a[3] = i_item.req.a_w;
    assign ld_b[0] = i_item.req.b_x;
    assign ld_b[1] = i_item.req.b_y;
    assign ld_b[2] = i_item.req.b_z;
    assign ld_b[3] = i_item.req.b_w;

    // multiplier operand selection
    assign rj      = axis_nxt1(r_comp);
    assign rk      = axis_nxt2(r_comp);
    assign hi      = {r_comp, r_k};
    assign inv_rot = (r_cls == CL_IROTV);

    always_comb begin
        mul_x   = '0;
        mul_y   = '0;
        mul_neg = 1'b0;
        unique case (r_phase)
            PH_HAB: begin
                mul_x = r_a[HAM_L[hi]]; mul_y = r_b[HAM_R[hi]]; mul_neg = HAM_N[hi];
            end
            PH_HBA: begin
                mul_x = r_b[HAM_L[hi]]; mul_y = r_a[HAM_R[hi]]; mul_neg = HAM_N[hi];
            end
            PH_HPQ: begin
                mul_x = r_p[HAM_L[hi]]; mul_y = r_q[HAM_R[hi]]; mul_neg = HAM_N[hi];
            end
            PH_SSA: begin
                mul_x = r_a[r_k]; mul_y = r_a[r_k];
            end
            PH_SSB: begin
                mul_x = r_b[r_k]; mul_y = r_b[r_k];
            end
            PH_ROT1: begin
                case (r_k)
                    2'd0: begin mul_x = r_b[rj]; mul_y = r_a[rk]; mul_neg = inv_rot; end
                    2'd1: begin mul_x = r_b[rk]; mul_y = r_a[rj]; mul_neg = ~inv_rot; end
                    2'd2: begin mul_x = r_b[3]; mul_y = r_a[r_comp]; end
                    default: ;
                endcase
            end
            PH_ROT2: begin
                case (r_k)
                    2'd0: begin mul_x = r_b[rj]; mul_y = r_p[rk]; mul_neg = inv_rot; end
                    2'd1: begin mul_x = r_b[rk]; mul_y = r_p[rj]; mul_neg = ~inv_rot; end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign mul_raw = mul_x * mul_y;
    assign mul_p   = mul_neg ? -PW'(mul_raw) : PW'(mul_raw);

    // rounding shifts at the end of an accumulation
    assign acc_rf = (r_acc + RND_F) >>> F;
    assign acc_r2 = (r_acc + RND_F2) >>> (F - 1);
    assign fin_rf = SW'(acc_rf);
    assign fin_r2 = SW'(acc_r2) + SW'(r_a[r_comp]);
    assign ss_big = $unsigned(r_acc) > ONE2;

    // square root step and final rounding
    assign s_sh      = {r_sqr[RMW-3:0], r_sqs[2*SQ-1 -: 2]};
    assign s_tr      = RMW'({r_root, 2'b01});
    assign s_ge      = (s_sh >= s_tr);
    assign mag_rnd   = (r_sqr > RMW'(r_root)) ? r_root + 1'b1 : r_root;
    assign mag_small = (mag_rnd <= TH_M);

    // divider setup: magnitude of numerator plus half the divisor
    assign d_src = (r_dinv && r_cls == CL_ROTQ) ? r_b[r_comp] : r_a[r_comp];
    assign d_sv  = (r_dinv && r_comp != 2'd3) ? -((W + 1)'(d_src)) : (W + 1)'(d_src);
    assign d_abs = d_sv[W] ? $unsigned(-d_sv) : $unsigned(d_sv);
    assign d_den = r_dinv ? NW'(r_ss) : NW'(r_mag);
    assign d_num = (r_dinv ? (NW'(d_abs) << (2 * F)) : (NW'(d_abs) << F)) + (d_den >> 1);

    // divider step and signed result
    assign v_sh = {r_rem[NW-1:0], r_num[NW-1]};
    assign v_ge = (v_sh >= {1'b0, r_den});
    assign q_s  = $signed(SW'(r_num));
    assign dval = r_dneg ? -q_s : q_s;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_vld) begin
                    case (i_item.cls)
                        CL_ADD, CL_CONJ, CL_NONE: n_state = ST_DONE;
                        default:                  n_state = ST_MAC;
                    endcase
                end
            end
            ST_MAC:   if (r_k == 2'd3) n_state = ST_DRAIN;
            ST_DRAIN: n_state = ST_FIN;
            ST_FIN: begin
                unique case (r_phase)
                    PH_HAB, PH_HPQ: n_state = (r_comp == 2'd3) ? ST_DONE : ST_MAC;
                    PH_ROT2:        n_state = (r_comp == 2'd2) ? ST_DONE : ST_MAC;
                    PH_HBA, PH_ROT1: n_state = ST_MAC;
                    PH_SSA: begin
                        if (r_cls != CL_INV) begin
                            n_state = ST_SQRT;
                        end else begin
                            n_state = ss_big ? ST_DSET : ST_DONE;
                        end
                    end
                    PH_SSB:  n_state = ss_big ? ST_DSET : ST_MAC;
                    default: n_state = ST_DONE;
                endcase
            end
            ST_SQRT: if (r_cnt == CW'(1)) n_state = ST_SQFIN;
            ST_SQFIN: begin
                n_state = (r_cls == CL_NORM && !mag_small) ? ST_DSET : ST_DONE;
            end
            ST_DSET: n_state = ST_DIV;
            ST_DIV:  if (r_cnt == CW'(1)) n_state = ST_DIVFIN;
            ST_DIVFIN: begin
                if (r_comp == 2'd3) begin
                    n_state = (r_cls == CL_ROTQ) ? ST_MAC : ST_DONE;
                end else begin
                    n_state = ST_DSET;
                end
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop  = (r_state == ST_IDLE) && i_vld;
        o_done = r_done;
        o_rsp  = r_rsp;
    end

    // datapath
    always_comb begin
        n_a = r_a; n_b = r_b; n_p = r_p; n_q = r_q; n_o = r_o;
        n_cls = r_cls; n_phase = r_phase; n_comp = r_comp; n_k = r_k;
        n_fl = r_fl; n_skip = r_skip; n_dinv = r_dinv;
        n_prod = '0;
        n_acc  = r_acc + ACCW'(r_prod);
        n_ss = r_ss; n_mag = r_mag; n_sqs = r_sqs; n_sqr = r_sqr; n_root = r_root;
        n_num = r_num; n_den = r_den; n_rem = r_rem; n_dneg = r_dneg; n_cnt = r_cnt;
        n_rsp  = r_rsp;
        n_done = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_vld) begin
                    n_cls  = i_item.cls;
                    n_a    = ld_a;
                    n_b    = ld_b;
                    n_fl   = 1'b0;
                    n_skip = 1'b0;
                    n_comp = 2'd0;
                    n_k    = 2'd0;
                    n_dinv = (i_item.cls == CL_INV) || (i_item.cls == CL_ROTQ);
                    for (int i = 0; i < 4; i++) begin
                        n_o[i] = '0;
                    end
                    case (i_item.cls)
                        CL_ADD: begin
                            for (int i = 0; i < 4; i++) begin
                                n_o[i] = sat_w(SW'(ld_a[i]) + SW'(ld_b[i]));
                                n_fl   = n_fl | sat_ov(SW'(ld_a[i]) + SW'(ld_b[i]));
                            end
                        end
                        CL_CONJ: begin
                            for (int i = 0; i < 4; i++) begin
                                n_o[i] = sat_w(conj_c(ld_a[i], 2'(i)));
                                n_fl   = n_fl | sat_ov(conj_c(ld_a[i], 2'(i)));
                            end
                        end
                        default: ;
                    endcase
                    case (i_item.cls)
                        CL_MUL:             n_phase = PH_HAB;
                        CL_ROTQ:            n_phase = PH_HBA;
                        CL_ROTV, CL_IROTV:  n_phase = PH_ROT1;
                        default:            n_phase = PH_SSA;
                    endcase
                end
            end
            ST_MAC: begin
                n_prod = mul_p;
                n_k    = r_k + 1'b1;
            end
            ST_FIN: begin
                n_acc = '0;
                unique case (r_phase)
                    PH_HAB, PH_HPQ: begin
                        n_o[r_comp] = sat_w(fin_rf);
                        n_fl        = r_fl | sat_ov(fin_rf);
                        n_comp      = r_comp + 1'b1;
                    end
                    PH_HBA: begin
                        n_p[r_comp] = sat_w(fin_rf);
                        n_fl        = r_fl | sat_ov(fin_rf);
                        n_comp      = r_comp + 1'b1;
                        if (r_comp == 2'd3) n_phase = PH_SSB;
                    end
                    PH_ROT1: begin
                        n_p[r_comp] = sat_w(fin_rf);
                        n_fl        = r_fl | sat_ov(fin_rf);
                        if (r_comp == 2'd2) begin
                            n_phase = PH_ROT2;
                            n_comp  = 2'd0;
                        end else begin
                            n_comp = r_comp + 1'b1;
                        end
                    end
                    PH_ROT2: begin
                        n_o[r_comp] = sat_w(fin_r2);
                        n_fl        = r_fl | sat_ov(fin_r2);
                        n_comp      = r_comp + 1'b1;
                    end
                    PH_SSA, PH_SSB: begin
                        n_ss   = $unsigned(r_acc);
                        n_comp = 2'd0;
                        if (r_phase == PH_SSA && r_cls != CL_INV) begin
                            n_sqs  = r_acc[2*SQ-1:0];
                            n_sqr  = '0;
                            n_root = '0;
                            n_cnt  = CW'(SQ);
                        end else if (!ss_big) begin
                            // small magnitude: inverse is the plain conjugate
                            for (int i = 0; i < 4; i++) begin
                                if (r_phase == PH_SSB) begin
                                    n_q[i] = sat_w(conj_c(r_b[i], 2'(i)));
                                    n_fl   = n_fl | sat_ov(conj_c(r_b[i], 2'(i)));
                                end else begin
                                    n_o[i] = sat_w(conj_c(r_a[i], 2'(i)));
                                    n_fl   = n_fl | sat_ov(conj_c(r_a[i], 2'(i)));
                                end
                            end
                            if (r_phase == PH_SSB) n_phase = PH_HPQ;
                        end
                    end
                    default: ;
                endcase
            end
            ST_SQRT: begin
                n_sqr  = s_ge ? s_sh - s_tr : s_sh;
                n_root = {r_root[SQ-1:0], s_ge};
                n_sqs  = r_sqs << 2;
                n_cnt  = r_cnt - 1'b1;
            end
            ST_SQFIN: begin
                n_mag = mag_rnd;
                if (r_cls == CL_MAG) begin
                    n_o[3] = sat_w($signed(SW'(mag_rnd)));
                    n_fl   = r_fl | sat_ov($signed(SW'(mag_rnd)));
                end else if (mag_small) begin
                    n_o    = r_a;
                    n_skip = 1'b1;
                end
            end
            ST_DSET: begin
                n_num  = d_num;
                n_den  = d_den;
                n_dneg = d_sv[W];
                n_rem  = '0;
                n_cnt  = CW'(NW);
            end
            ST_DIV: begin
                n_rem = v_ge ? v_sh - {1'b0, r_den} : v_sh;
                n_num = {r_num[NW-2:0], v_ge};
                n_cnt = r_cnt - 1'b1;
            end
            ST_DIVFIN: begin
                if (r_cls == CL_ROTQ) begin
                    n_q[r_comp] = sat_w(dval);
                end else begin
                    n_o[r_comp] = sat_w(dval);
                end
                n_fl   = r_fl | sat_ov(dval);
                n_comp = r_comp + 1'b1;
                if (r_comp == 2'd3 && r_cls == CL_ROTQ) n_phase = PH_HPQ;
            end
            ST_DONE: begin
                n_done = 1'b1;
                n_rsp  = '{r_x: r_o[0], r_y: r_o[1], r_z: r_o[2], r_w: r_o[3],
                           saturated: r_fl, norm_skipped: r_skip};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
            r_acc   <= '0;
            r_prod  <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_acc   <= n_acc;
            r_prod  <= n_prod;
        end
        r_a <= n_a; r_b <= n_b; r_p <= n_p; r_q <= n_q; r_o <= n_o;
        r_cls <= n_cls; r_phase <= n_phase; r_comp <= n_comp; r_k <= n_k;
        r_fl <= n_fl; r_skip <= n_skip; r_dinv <= n_dinv;
        r_ss <= n_ss; r_mag <= n_mag; r_sqs <= n_sqs; r_sqr <= n_sqr; r_root <= n_root;
        r_num <= n_num; r_den <= n_den; r_rem <= n_rem; r_dneg <= n_dneg; r_cnt <= n_cnt;
        r_rsp <= n_rsp;
    end

endmodule

`default_nettype wire

@@ bench/qau_result_checker.sv @@
// qau_result_checker: predicts every quaternion unit result and compares it
// depends on qau_pkg; watches the request and result channels of the core
`timescale 1ns / 1ps

module qau_result_checker #(
    parameter int FRAC_BITS = 28
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  qau_pkg::t_req i_req,
    input  logic          i_done,
    input  qau_pkg::t_rsp i_rsp,
    output int            o_fail_count,
    output int            o_pending
);
    import qau_pkg::*;

    typedef logic signed [127:0] wide_t;
    typedef longint quat_t [4];

    localparam longint WMAX = (longint'(1) <<< (WORD_BITS - 1)) - 1;
    localparam longint WMIN = -WMAX - 1;
    localparam longint ONE_Q = longint'(1) <<< FRAC_BITS;
    localparam longint THRESH_Q = (ONE_Q + 10) / 20;

    t_rsp expected_rsp_q[$];
    int   fail_cnt = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = expected_rsp_q.size();

    function automatic wide_t mulw(longint x, longint y);
        return wide_t'(x) * wide_t'(y);
    endfunction

    // round half up then arithmetic shift
    function automatic wide_t rnd_shift(wide_t a, int s);
        return (a + (wide_t'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(wide_t a, inout bit fl);
        if (a < wide_t'(WMIN)) begin
            fl = 1'b1;
            return WMIN;
        end
        if (a > wide_t'(WMAX)) begin
            fl = 1'b1;
            return WMAX;
        end
        return longint'(a);
    endfunction

    // positive denominator, rounded half away from zero
    function automatic wide_t div_round(wide_t n, wide_t d);
        bit    neg;
        wide_t m;
        wide_t q;
        neg = n < 0;
        m   = neg ? -n : n;
        q   = (m + (d >>> 1)) / d;
        return neg ? -q : q;
    endfunction

    function automatic wide_t sum_sq(quat_t q);
        return mulw(q[0], q[0]) + mulw(q[1], q[1]) + mulw(q[2], q[2]) + mulw(q[3], q[3]);
    endfunction

    // rounded square root
    function automatic longint sqrt_round(wide_t s);
        wide_t res;
        wide_t c;
        res = 0;
        for (int b = 49; b >= 0; b--) begin
            c = res | (wide_t'(1) <<< b);
            if (!(s < c * c)) res = c;
        end
        if (res * res + res < s) res = res + 1;
        return longint'(res);
    endfunction

    function automatic void hamilton(quat_t a, quat_t b, output quat_t o, inout bit fl);
        wide_t t;
        t = mulw(a[3], b[0]) - mulw(a[2], b[1]) + mulw(a[0], b[3]) + mulw(a[1], b[2]);
        o[0] = clamp(rnd_shift(t, FRAC_BITS), fl);
        t = mulw(a[3], b[1]) - mulw(a[0], b[2]) + mulw(a[1], b[3]) + mulw(a[2], b[0]);
        o[1] = clamp(rnd_shift(t, FRAC_BITS), fl);
        t = mulw(a[3], b[2]) + mulw(a[0], b[1]) - mulw(a[1], b[0]) + mulw(a[2], b[3]);
        o[2] = clamp(rnd_shift(t, FRAC_BITS), fl);
        t = mulw(a[3], b[3]) - mulw(a[0], b[0]) - mulw(a[1], b[1]) - mulw(a[2], b[2]);
        o[3] = clamp(rnd_shift(t, FRAC_BITS), fl);
    endfunction

    // conjugate, scaled only when the squared magnitude exceeds one
    function automatic void inverse_of(quat_t q, output quat_t o, inout bit fl);
        wide_t ss;
        wide_t c;
        ss = sum_sq(q);
        for (int i = 0; i < 4; i++) begin
            c = (i < 3) ? -wide_t'(q[i]) : wide_t'(q[i]);
            if (ss > (wide_t'(1) <<< (2 * FRAC_BITS)))
                c = div_round(c <<< (2 * FRAC_BITS), ss);
            o[i] = clamp(c, fl);
        end
    endfunction

    function automatic void rotate_vec(quat_t v, quat_t b, bit inv, output quat_t o,
                                       inout bit fl);
        longint r[3];
        longint t[3];
        int     j;
        int     k;
        wide_t  acc;
        for (int i = 0; i < 3; i++) r[i] = inv ? -b[i] : b[i];
        for (int i = 0; i < 3; i++) begin
            j = (i + 1) % 3;
            k = (i + 2) % 3;
            acc = mulw(r[j], v[k]) - mulw(r[k], v[j]) + mulw(b[3], v[i]);
            t[i] = clamp(rnd_shift(acc, FRAC_BITS), fl);
        end
        for (int i = 0; i < 3; i++) begin
            j = (i + 1) % 3;
            k = (i + 2) % 3;
            acc = mulw(r[j], t[k]) - mulw(r[k], t[j]);
            o[i] = clamp(rnd_shift(acc, FRAC_BITS - 1) + wide_t'(v[i]), fl);
        end
        o[3] = 0;
    endfunction

    function automatic t_rsp predict_quat_op(t_req rq);
        quat_t  a;
        quat_t  b;
        quat_t  o;
        quat_t  p;
        quat_t  ib;
        bit     fl;
        bit     skip;
        longint mag;
        t_rsp   rs;
        a = '{rq.a_x, rq.a_y, rq.a_z, rq.a_w};
        b = '{rq.b_x, rq.b_y, rq.b_z, rq.b_w};
        o = '{0, 0, 0, 0};
        fl = 1'b0;
        skip = 1'b0;
        case (rq.opcode)
            OP_ADD: for (int i = 0; i < 4; i++) o[i] = clamp(wide_t'(a[i] + b[i]), fl);
            OP_MUL: hamilton(a, b, o, fl);
            OP_CONJ: begin
                for (int i = 0; i < 3; i++) o[i] = clamp(-wide_t'(a[i]), fl);
                o[3] = a[3];
            end
            OP_INV: inverse_of(a, o, fl);
            OP_MAG: begin
                mag = sqrt_round(sum_sq(a));
                o[3] = clamp(wide_t'(mag), fl);
            end
            OP_NORM: begin
                mag = sqrt_round(sum_sq(a));
                if (mag <= THRESH_Q) begin
                    o = a;
                    skip = 1'b1;
                end else begin
                    for (int i = 0; i < 4; i++)
                        o[i] = clamp(div_round(wide_t'(a[i]) <<< FRAC_BITS, wide_t'(mag)), fl);
                end
            end
            OP_ROTQ: begin
                hamilton(b, a, p, fl);
                inverse_of(b, ib, fl);
                hamilton(p, ib, o, fl);
            end
            OP_ROTV:  rotate_vec(a, b, 1'b0, o, fl);
            OP_IROTV: rotate_vec(a, b, 1'b1, o, fl);
            default: ;
        endcase
        rs.r_x = o[0][WORD_BITS-1:0];
        rs.r_y = o[1][WORD_BITS-1:0];
        rs.r_z = o[2][WORD_BITS-1:0];
        rs.r_w = o[3][WORD_BITS-1:0];
        rs.saturated = fl;
        rs.norm_skipped = skip;
        return rs;
    endfunction

    // accepted requests and strobed results, sampled at the rising edge
    always @(posedge i_clk) begin
        t_rsp e;
        if (i_rst_n && i_start && !i_busy)
            expected_rsp_q.push_back(predict_quat_op(i_req));
        if (i_rst_n && i_done) begin
            if (expected_rsp_q.size() == 0) begin
                $error("result with no request outstanding");
                fail_cnt = fail_cnt + 1;
            end else begin
                e = expected_rsp_q.pop_front();
                if (e.r_x !== i_rsp.r_x) begin
                    $error("r_x expected %0d actual %0d", e.r_x, i_rsp.r_x);
                    fail_cnt = fail_cnt + 1;
                end
                if (e.r_y !== i_rsp.r_y) begin
                    $error("r_y expected %0d actual %0d", e.r_y, i_rsp.r_y);
                    fail_cnt = fail_cnt + 1;
                end
                if (e.r_z !== i_rsp.r_z) begin
                    $error("r_z expected %0d actual %0d", e.r_z, i_rsp.r_z);
                    fail_cnt = fail_cnt + 1;
                end
                if (e.r_w !== i_rsp.r_w) begin
                    $error("r_w expected %0d actual %0d", e.r_w, i_rsp.r_w);
                    fail_cnt = fail_cnt + 1;
                end
                if (e.saturated !== i_rsp.saturated) begin
                    $error("saturated expected %0b actual %0b", e.saturated, i_rsp.saturated);
                    fail_cnt = fail_cnt + 1;
                end
                if (e.norm_skipped !== i_rsp.norm_skipped) begin
                    $error("norm_skipped expected %0b actual %0b",
                           e.norm_skipped, i_rsp.norm_skipped);
                    fail_cnt = fail_cnt + 1;
                end
            end
        end
    end

endmodule

@@ bench/tb_quaternion_arithmetic_unit_core.sv @@
// tb_quaternion_arithmetic_unit_core: drives quaternion requests and gives the verdict
// depends on qau_pkg, qau_result_checker and the quaternion_arithmetic_unit_core block
`timescale 1ns / 1ps

module tb_quaternion_arithmetic_unit_core;
    import qau_pkg::*;

    localparam int FRAC_BITS    = 28;
    localparam int RANDOM_ITEMS = 1530;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 600;

    localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
    localparam logic signed [31:0] MINV = 32'sh8000_0000;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    t_req  req = '0;
    logic  busy;
    logic  done;
    t_rsp  rsp;
    int    fail_count;
    int    pending;
    int    idle_pct = 0;
    int    quiet_cycles = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    quaternion_arithmetic_unit_core #(.FRAC_BITS(FRAC_BITS)) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .start   (start),
        .i_req   (req),
        .busy    (busy),
        .o_done  (done),
        .o_rsp   (rsp)
    );

    qau_result_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (req),
        .i_done       (done),
        .i_rsp        (rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // watchdog on cycles with no request taken and no result
    always @(posedge clk) begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // one request, with a random idle gap first; returns at the falling edge
    // with start still high, so the next call or the caller drops it
    task automatic send_request(t_req r);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    function automatic logic signed [31:0] rand_comp(int style);
        logic signed [31:0] v;
        case (style)
            0: v = $urandom;
            1: v = $signed($urandom_range(2 * ONE)) - ONE;
            2: v = $signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
            3: v = ($urandom_range(1)) ? MAXV : MINV;
            default: v = $signed($urandom_range(8 * ONE)) - 4 * ONE;
        endcase
        return v;
    endfunction

    function automatic t_req rand_request();
        t_req r;
        int   style;
        style = $urandom_range(9);
        r.opcode = ($urandom_range(15) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
        r.a_x = rand_comp(style % 5);
        r.a_y = rand_comp(style % 5);
        r.a_z = rand_comp(style % 5);
        r.a_w = rand_comp(style % 5);
        r.b_x = rand_comp(style < 5 ? 1 : $urandom_range(4));
        r.b_y = rand_comp(style < 5 ? 1 : $urandom_range(4));
        r.b_z = rand_comp(style < 5 ? 1 : $urandom_range(4));
        r.b_w = rand_comp(style < 5 ? 1 : $urandom_range(4));
        // a near-unit rotation quaternion most of the time
        if (r.opcode >= OP_ROTQ && r.opcode <= OP_IROTV && $urandom_range(3) != 0) begin
            r.b_x = $signed($urandom_range(ONE)) - (ONE >>> 1);
            r.b_y = $signed($urandom_range(ONE >>> 1)) - (ONE >>> 2);
            r.b_z = $signed($urandom_range(ONE >>> 1)) - (ONE >>> 2);
            r.b_w = ONE - (r.b_x >>> 2);
        end
        return r;
    endfunction

    initial begin
        t_req d;
        t_req directed_q[$];
        // directed: extremes, each operation and the named corner cases
        for (int op = 0; op <= 8; op++) begin
            d = '{4'(op), MAXV, MINV, ONE, -ONE, ONE >>> 1, MAXV, MINV, ONE};
            directed_q.push_back(d);
        end
        directed_q.push_back('{OP_CONJ, MINV, MINV, MINV, MINV, 0, 0, 0, 0});
        directed_q.push_back('{OP_ADD, MAXV, MINV, MAXV, MINV, MAXV, MINV, 1, -1});
        directed_q.push_back('{OP_MUL, MAXV, MAXV, MAXV, MAXV, MINV, MINV, MINV, MINV});
        directed_q.push_back('{OP_INV, 0, 0, 0, ONE, 0, 0, 0, 0});
        directed_q.push_back('{OP_INV, ONE, ONE, ONE, ONE, 0, 0, 0, 0});
        directed_q.push_back('{OP_INV, 0, 0, 0, 0, 0, 0, 0, 0});
        directed_q.push_back('{OP_MAG, MINV, MINV, MINV, MINV, 0, 0, 0, 0});
        directed_q.push_back('{OP_NORM, 0, 0, 0, 0, 0, 0, 0, 0});
        directed_q.push_back('{OP_NORM, 0, 0, 0, 32'sd13421773, 0, 0, 0, 0});
        directed_q.push_back('{OP_NORM, 0, 0, 0, 32'sd13421774, 0, 0, 0, 0});
        directed_q.push_back('{OP_NORM, MAXV, MAXV, MAXV, MAXV, 0, 0, 0, 0});
        directed_q.push_back('{OP_ROTV, ONE, 0, 0, MAXV, 0, 0, ONE >>> 1, ONE >>> 1});
        directed_q.push_back('{OP_IROTV, MAXV, MINV, MAXV, 0, MAXV, MAXV, MAXV, MAXV});
        directed_q.push_back('{OP_ROTQ, ONE, ONE, 0, 0, ONE, ONE, ONE, ONE});
        directed_q.push_back('{4'd9, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV});
        directed_q.push_back('{4'd15, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV});

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_q[i]) send_request(directed_q[i]);
        // random phases: no idling, heavy idling, none, light idling
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case ((n * 4) / RANDOM_ITEMS)
                0:       idle_pct = 0;
                1:       idle_pct = 82;
                2:       idle_pct = 0;
                default: idle_pct = 24;
            endcase
            send_request(rand_request());
        end
        start <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
